### design/ftca_pkg.sv
// ----------------------------------------------------------------------------
// ftca_pkg
// Shared types, codes and entry helpers for the cluster allocator.
// ----------------------------------------------------------------------------
package ftca_pkg;

   localparam int IDX_W         = 12;
   localparam int TABLE_ENTRIES = 1 << IDX_W;
   localparam int LIM_W         = 13;
   localparam int ENTRY_W       = 28;
   localparam int CSR_IDX_W     = 2;

   localparam logic [31:0] MASK28        = 32'h0FFF_FFFF;
   localparam logic [31:0] MASK16        = 32'h0000_FFFF;
   localparam logic [31:0] RESV_BITS     = 32'hF000_0000;
   localparam logic [31:0] COUNT_UNKNOWN = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_ALLOC = 2'd2,
      OP_FREE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAT_IS_32      = 2'd0,
      CSR_ENTRIES_IN_USE = 2'd1,
      CSR_FSINFO_PRESENT = 2'd2,
      CSR_INIT_FREE_CNT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      WK_CLEAR = 3'd0,
      WK_VALUE = 3'd1,
      WK_ZERO  = 3'd2,
      WK_MARK  = 3'd3,
      WK_LINK  = 3'd4
   } wr_kind_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   cluster;
      logic [31:0]        value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [IDX_W-1:0]   new_cluster;
      logic [ENTRY_W-1:0] entry;
   } rsp_type;

   typedef struct packed {
      logic        req_load;
      logic        rd_en;
      logic        rd_scan;
      logic        wr_en;
      wr_kind_type wr_kind;
      logic        scan_clr;
      logic        clr_step;
      logic        info_take;
      logic        info_give;
      logic        rsp_load;
      status_type  rsp_status;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   cl_zero;
      logic   cl_in_range;
      logic   lim_zero;
      logic   scan_hit;
      logic   scan_end;
      logic   clr_last;
      logic   rsp_busy;
   } dp_status_type;

   function automatic logic [31:0] entry_mask(input logic fat32, input logic [31:0] v);
      entry_mask = v & (fat32 ? MASK28 : MASK16);
   endfunction

   function automatic logic [31:0] entry_merge(input logic fat32, input logic [31:0] old,
                                               input logic [31:0] v);
      entry_merge = fat32 ? ((old & RESV_BITS) | (v & MASK28)) : (v & MASK16);
   endfunction

endpackage

### design/fat_table_cluster_allocator_unit.sv
// ----------------------------------------------------------------------------
// fat_table_cluster_allocator_unit
// Read, write and free pass through decode, access and response; range errors
// and allocate with a zero limit go from decode straight to response. Allocate
// scans for the first free entry, marks it, and links it when the cluster is
// nonzero; out of space ends the scan with a full status. One item in flight:
// the next transfer is taken the cycle after the result is loaded. Synchronous
// reset starts a clearing pass of the whole table with req_stall high.
// ----------------------------------------------------------------------------
module fat_table_cluster_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  ftca_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output ftca_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ftca_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);
   import ftca_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   ftca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ftca_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### design/ftca_ctrl.sv
// ----------------------------------------------------------------------------
// ftca_ctrl
// Sequencer: table clearing, decode, access, first-fit scan, mark, link, response.
// ----------------------------------------------------------------------------
module ftca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ftca_pkg::dp_status_type sts,
   output ftca_pkg::ctrl_cmd_type  cmd
);
   import ftca_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ACCESS,
      S_SCAN,
      S_MARK,
      S_LINK_RD,
      S_LINK_WR,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.rsp_status = code_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_kind  = WK_CLEAR;
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_load = req_valid;
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            code_in = ST_OK;
            if (sts.op == OP_ALLOC) begin
               if (!sts.cl_zero && !sts.cl_in_range) begin
                  code_in  = ST_RANGE;
                  state_in = S_RESP;
               end else if (sts.lim_zero) begin
                  code_in  = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  cmd.scan_clr = 1'b1;
                  state_in     = S_SCAN;
               end
            end else if (!sts.cl_in_range) begin
               code_in  = ST_RANGE;
               state_in = S_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_ACCESS;
            end
         end
         S_ACCESS: begin
            case (sts.op)
               OP_WRITE: begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_kind = WK_VALUE;
               end
               OP_FREE: begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_kind   = WK_ZERO;
                  cmd.info_give = 1'b1;
               end
               default: ;
            endcase
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (sts.scan_hit) begin
               state_in = S_MARK;
            end else if (sts.scan_end) begin
               code_in  = ST_FULL;
               state_in = S_RESP;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_scan = 1'b1;
            end
         end
         S_MARK: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_kind   = WK_MARK;
            cmd.info_take = 1'b1;
            state_in      = sts.cl_zero ? S_RESP : S_LINK_RD;
         end
         S_LINK_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LINK_WR;
         end
         S_LINK_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_kind = WK_LINK;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

### design/ftca_datapath.sv
// ----------------------------------------------------------------------------
// ftca_datapath
// Table memory, configuration, scan counter, info upkeep and response register.
// ----------------------------------------------------------------------------
module ftca_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ftca_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ftca_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ftca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata,
   input  ftca_pkg::ctrl_cmd_type            cmd,
   output ftca_pkg::dp_status_type           sts
);
   import ftca_pkg::*;

   logic [31:0]      table_mem [TABLE_ENTRIES];

   logic             fat32_ff;
   logic [LIM_W-1:0] eiu_ff;
   logic             fsinfo_ff;
   logic [31:0]      init_free_ff;
   logic [31:0]      free_cnt_ff;
   logic [IDX_W-1:0] hint_ff;

   req_type          req_ff;
   logic [31:0]      rd_data_ff;
   logic [IDX_W-1:0] scan_ff;
   logic [IDX_W-1:0] tag_ff;
   logic             tag_valid_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic [LIM_W-1:0] lim;
   logic [31:0]      rd_view;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [31:0]      wr_data;
   logic             info_en;
   logic [IDX_W-1:0] info_idx;
   logic             csr_wr;
   rsp_type          rsp_in;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   assign lim = (eiu_ff > LIM_W'(TABLE_ENTRIES)) ? LIM_W'(TABLE_ENTRIES) : eiu_ff;

   assign rd_view = entry_mask(fat32_ff, rd_data_ff);

   assign sts.op          = req_ff.op;
   assign sts.cl_zero     = (req_ff.cluster == '0);
   assign sts.cl_in_range = ({1'b0, req_ff.cluster} < lim);
   assign sts.lim_zero    = (lim == '0);
   assign sts.scan_hit    = tag_valid_ff && (rd_view == '0);
   assign sts.scan_end    = tag_valid_ff && ({1'b0, tag_ff} == lim - LIM_W'(1));
   assign sts.clr_last    = (scan_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.rsp_busy    = rsp_valid_ff & rsp_stall;

   assign rd_addr = cmd.rd_scan ? scan_ff : req_ff.cluster;

   always_comb begin
      wr_addr = req_ff.cluster;
      wr_data = '0;
      case (cmd.wr_kind)
         WK_CLEAR: begin
            wr_addr = scan_ff;
            wr_data = '0;
         end
         WK_VALUE: wr_data = entry_merge(fat32_ff, rd_data_ff, req_ff.value);
         WK_ZERO:  wr_data = entry_merge(fat32_ff, rd_data_ff, 32'd0);
         WK_MARK: begin
            wr_addr = tag_ff;
            wr_data = entry_merge(fat32_ff, rd_data_ff, fat32_ff ? MASK28 : MASK16);
         end
         WK_LINK:  wr_data = entry_merge(fat32_ff, rd_data_ff, {{(32-IDX_W){1'b0}}, tag_ff});
         default:  wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) table_mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= table_mem[rd_addr];
   end

   assign info_en  = (cmd.info_take | cmd.info_give) & fat32_ff & fsinfo_ff;
   assign info_idx = cmd.info_take ? tag_ff : req_ff.cluster;

   always_ff @(posedge clock) begin
      if (reset) begin
         fat32_ff     <= 1'b1;
         eiu_ff       <= LIM_W'(TABLE_ENTRIES);
         fsinfo_ff    <= 1'b1;
         init_free_ff <= COUNT_UNKNOWN;
         free_cnt_ff  <= COUNT_UNKNOWN;
         hint_ff      <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index_type'(csr_index))
               CSR_FAT_IS_32:      fat32_ff  <= csr_wdata[0];
               CSR_ENTRIES_IN_USE: eiu_ff    <= csr_wdata[LIM_W-1:0];
               CSR_FSINFO_PRESENT: fsinfo_ff <= csr_wdata[0];
               CSR_INIT_FREE_CNT: begin
                  init_free_ff <= csr_wdata;
                  free_cnt_ff  <= csr_wdata;
               end
               default: ;
            endcase
         end
         if (info_en) begin
            if (free_cnt_ff != COUNT_UNKNOWN)
               free_cnt_ff <= cmd.info_take ? free_cnt_ff - 32'd1 : free_cnt_ff + 32'd1;
            if (info_idx != '0) hint_ff <= info_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= '0;
         tag_ff       <= '0;
         tag_valid_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         scan_ff      <= '0;
         tag_valid_ff <= 1'b0;
      end else if (cmd.clr_step) begin
         scan_ff <= scan_ff + IDX_W'(1);
      end else if (cmd.rd_en && cmd.rd_scan) begin
         scan_ff      <= scan_ff + IDX_W'(1);
         tag_ff       <= scan_ff;
         tag_valid_ff <= 1'b1;
      end
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = cmd.rsp_status;
      if (cmd.rsp_status == ST_OK && req_ff.op == OP_ALLOC)
         rsp_in.new_cluster = tag_ff;
      if (cmd.rsp_status == ST_OK && req_ff.op == OP_READ)
         rsp_in.entry = rd_view[ENTRY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/ftca_checker.sv
// ----------------------------------------------------------------------------
// ftca_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ftca_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ftca_pkg::rsp_type rsp_data
);
   import ftca_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.new_cluster == '0 &&
                                                rsp_data.entry == '0)
      else $error("failed item carries data");

   a_alloc_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_cluster != '0 |-> rsp_data.entry == '0 &&
                                                 rsp_data.status == ST_OK)
      else $error("allocate result carries an entry");

   a_clear_stall: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input open during table clearing");

endmodule

bind fat_table_cluster_allocator_unit ftca_checker u_ftca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/fat_table_cluster_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// fat_table_cluster_allocator_unit_tb
// Self-checking bench for the cluster allocator. A short directed table covers
// reset contents, FAT16/FAT32 masking, chain linking, self links, range errors
// and out of space. Random phases under several register settings follow.
// Each result is checked against its row's expected value or a table model in the bench.
// ----------------------------------------------------------------------------
module fat_table_cluster_allocator_unit_tb;
   import ftca_pkg::*;

   typedef struct {
      bit            is_csr;
      csr_index_type ci;
      logic [31:0]   cv;
      req_type       it;
      bit            typed;
      rsp_type       want;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   logic [31:0]    tab_copy [TABLE_ENTRIES];
   logic           m_fat32;
   logic [LIM_W-1:0] m_entries;
   logic           m_info;
   logic [31:0]    m_free_cnt;
   logic [31:0]    m_hint;

   rsp_type        rsp_owed [$];
   dir_row_type    dir_rows [$];
   logic [IDX_W-1:0] last_new = '0;
   bit             quiet = 1'b0;
   bit             calm = 1'b0;
   int             mismatch_count = 0;
   int             reqs_sent = 0;
   int             rsp_seen = 0;
   int             full_seen = 0;
   int             range_seen = 0;
   int             settings_used = 0;

   fat_table_cluster_allocator_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---- table model ----
   function automatic int unsigned eff_limit();
      return (m_entries > TABLE_ENTRIES) ? TABLE_ENTRIES : m_entries;
   endfunction

   function automatic logic [31:0] entry_view(int unsigned idx);
      return tab_copy[idx] & (m_fat32 ? MASK28 : MASK16);
   endfunction

   function automatic void entry_store(int unsigned idx, logic [31:0] v);
      if (m_fat32) begin
         tab_copy[idx] = (tab_copy[idx] & RESV_BITS) | (v & MASK28);
      end else begin
         tab_copy[idx] = v & MASK16;
      end
   endfunction

   function automatic void info_note(bit taking, int unsigned idx);
      if (m_fat32 && m_info) begin
         if (m_free_cnt != COUNT_UNKNOWN) begin
            m_free_cnt = taking ? m_free_cnt - 32'd1 : m_free_cnt + 32'd1;
         end
         if (idx != 0) begin
            m_hint = idx;
         end
      end
   endfunction

   function automatic rsp_type fat_table_op(req_type it);
      int unsigned lim;
      int unsigned k;
      int unsigned cl;
      bit          hit;
      logic [31:0] ent;
      rsp_type     r;
      lim = eff_limit();
      cl = it.cluster;
      hit = 1'b0;
      r = '0;
      r.status = ST_OK;
      if (it.op == OP_ALLOC) begin
         if (cl != 0 && cl >= lim) begin
            r.status = ST_RANGE;
         end else begin
            for (k = 0; k < lim; k++) begin
               if (!hit && entry_view(k) == 0) begin
                  hit = 1'b1;
                  r.new_cluster = k[IDX_W-1:0];
               end
            end
            if (!hit) begin
               r.status = ST_FULL;
            end else begin
               entry_store(r.new_cluster, m_fat32 ? MASK28 : MASK16);
               info_note(1'b1, r.new_cluster);
               if (cl != 0) begin
                  entry_store(cl, r.new_cluster);
               end
            end
         end
      end else if (cl >= lim) begin
         r.status = ST_RANGE;
      end else begin
         case (it.op)
            OP_READ: begin
               ent = entry_view(cl);
               r.entry = ent[ENTRY_W-1:0];
            end
            OP_WRITE: entry_store(cl, it.value);
            default: begin
               entry_store(cl, 32'd0);
               info_note(1'b0, cl);
            end
         endcase
      end
      return r;
   endfunction

   // ---- directed table builders ----
   function automatic void dir_item(op_type op, logic [IDX_W-1:0] cl, logic [31:0] val,
                                    bit typed, status_type st, logic [IDX_W-1:0] nc,
                                    logic [ENTRY_W-1:0] ent);
      dir_row_type row;
      row.is_csr = 1'b0;
      row.ci = CSR_FAT_IS_32;
      row.cv = '0;
      row.it.op = op;
      row.it.cluster = cl;
      row.it.value = val;
      row.typed = typed;
      row.want.status = st;
      row.want.new_cluster = nc;
      row.want.entry = ent;
      dir_rows.push_back(row);
   endfunction

   function automatic void dir_csr(csr_index_type ci, logic [31:0] cv);
      dir_row_type row;
      row.is_csr = 1'b1;
      row.ci = ci;
      row.cv = cv;
      row.it = '0;
      row.typed = 1'b0;
      row.want = '0;
      dir_rows.push_back(row);
   endfunction

   // ---- drivers ----
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic send_req(input req_type it, input bit typed, input rsp_type want);
      rsp_type pred;
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      pred = fat_table_op(it);
      rsp_owed.push_back(typed ? want : pred);
      if (it.op == OP_ALLOC && pred.status == ST_OK) begin
         last_new = pred.new_cluster;
      end
      reqs_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_owed.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAT_IS_32:      m_fat32 = val[0];
         CSR_ENTRIES_IN_USE: m_entries = val[LIM_W-1:0];
         CSR_FSINFO_PRESENT: m_info = val[0];
         default: begin
            m_free_cnt = val;
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic fat32, input logic [LIM_W-1:0] ents, input logic info,
                            input logic [31:0] cnt, input int count, input bit no_idle);
      req_type     it;
      int unsigned lim;
      int          n;
      wait_drained();
      csr_write(CSR_FAT_IS_32, {31'd0, fat32});
      csr_write(CSR_ENTRIES_IN_USE, {19'd0, ents});
      csr_write(CSR_FSINFO_PRESENT, {31'd0, info});
      csr_write(CSR_INIT_FREE_CNT, cnt);
      quiet = no_idle;
      settings_used++;
      for (n = 0; n < count; n++) begin
         lim = eff_limit();
         it.value = $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: it.op = OP_ALLOC;
            4, 5:       it.op = OP_FREE;
            6, 7:       it.op = OP_READ;
            default:    it.op = OP_WRITE;
         endcase
         case ($urandom_range(0, 9))
            0:       it.cluster = $urandom_range(0, TABLE_ENTRIES - 1);
            1:       it.cluster = (lim >= TABLE_ENTRIES) ? '1 : lim[IDX_W-1:0];
            2, 3:    it.cluster = last_new;
            4:       it.cluster = '0;
            default: it.cluster = (lim == 0) ? '0 : $urandom_range(0, lim - 1);
         endcase
         case ($urandom_range(0, 7))
            0, 1:    it.value = '0;
            2:       it.value = '1;
            default: ;
         endcase
         send_req(it, 1'b0, '0);
      end
   endtask

   // ---- result pacing: stall bursts, with calm stretches ----
   initial begin : rsp_pacing
      int left;
      int tick;
      rsp_stall = 1'b0;
      left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 40 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         if (left > 0) begin
            left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---- result check ----
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (rsp_owed.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_data.entry, '0);
         end else begin
            want = rsp_owed.pop_front();
            if (want.status == ST_FULL) full_seen++;
            if (want.status == ST_RANGE) range_seen++;
            if (rsp_data.status !== want.status) begin
               report_mismatch("status", rsp_data.status, want.status);
            end
            if (rsp_data.new_cluster !== want.new_cluster) begin
               report_mismatch("new_cluster", rsp_data.new_cluster, want.new_cluster);
            end
            if (rsp_data.entry !== want.entry) begin
               report_mismatch("entry", rsp_data.entry, want.entry);
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type row;
      int          i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
         tab_copy[i] = '0;
      end
      m_fat32 = 1'b1;
      m_entries = 13'd4096;
      m_info = 1'b1;
      m_free_cnt = COUNT_UNKNOWN;
      m_hint = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: FAT32, full table, count unknown
      dir_item(OP_READ,  12'd0,    '0,    1'b1, ST_OK, '0, '0);
      dir_item(OP_READ,  12'hFFF,  '0,    1'b1, ST_OK, '0, '0);
      dir_item(OP_WRITE, 12'd5,    '1,    1'b1, ST_OK, '0, '0);
      dir_item(OP_READ,  12'd5,    '0,    1'b1, ST_OK, '0, 28'hFFF_FFFF);
      dir_item(OP_ALLOC, 12'd0,    '0,    1'b1, ST_OK, 12'd0, '0);
      dir_item(OP_ALLOC, 12'd0,    '0,    1'b1, ST_OK, 12'd1, '0);
      dir_item(OP_ALLOC, 12'd1,    '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_READ,  12'd1,    '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_ALLOC, 12'hFFF,  '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_READ,  12'hFFF,  '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_FREE,  12'd1,    '0,    1'b1, ST_OK, '0, '0);
      // freed entry is found again and linked to itself
      dir_item(OP_ALLOC, 12'd1,    '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_READ,  12'd1,    '0,    1'b0, ST_OK, '0, '0);
      dir_item(OP_WRITE, 12'hFFF,  '0,    1'b1, ST_OK, '0, '0);
      dir_item(OP_FREE,  12'd0,    '0,    1'b1, ST_OK, '0, '0);
      dir_csr(CSR_FAT_IS_32, 32'd0);
      dir_csr(CSR_ENTRIES_IN_USE, 32'd16);
      dir_csr(CSR_FSINFO_PRESENT, 32'd0);
      dir_csr(CSR_INIT_FREE_CNT, 32'd0);
      dir_item(OP_WRITE, 12'd9,    '1,    1'b1, ST_OK, '0, '0);
      dir_item(OP_READ,  12'd9,    '0,    1'b1, ST_OK, '0, 28'h000_FFFF);
      dir_item(OP_READ,  12'd16,   '0,    1'b1, ST_RANGE, '0, '0);
      dir_item(OP_WRITE, 12'hFFF,  '0,    1'b1, ST_RANGE, '0, '0);
      dir_item(OP_FREE,  12'd16,   '0,    1'b1, ST_RANGE, '0, '0);
      dir_item(OP_ALLOC, 12'd16,   '0,    1'b1, ST_RANGE, '0, '0);
      dir_item(OP_ALLOC, 12'd15,   '0,    1'b0, ST_OK, '0, '0);
      // zero limit: nothing in range, nothing to allocate
      dir_csr(CSR_ENTRIES_IN_USE, 32'd0);
      dir_item(OP_ALLOC, 12'd0,    '0,    1'b1, ST_FULL, '0, '0);
      dir_item(OP_READ,  12'd0,    '0,    1'b1, ST_RANGE, '0, '0);
      dir_item(OP_FREE,  12'd0,    '0,    1'b1, ST_RANGE, '0, '0);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.is_csr) begin
            wait_drained();
            csr_write(row.ci, row.cv);
         end else begin
            send_req(row.it, row.typed, row.want);
         end
      end

      run_phase(1'b1, 13'd32,   1'b1, 32'd32,        20, 1'b0);
      run_phase(1'b0, 13'd1,    1'b1, 32'd5,         12, 1'b0);
      run_phase(1'b1, 13'd8191, 1'b1, 32'd0,         20, 1'b0);
      run_phase(1'b0, 13'd24,   1'b0, 32'hFFFF_FFFF, 20, 1'b0);
      run_phase(1'b1, 13'd4096, 1'b0, 32'd1000,      20, 1'b0);
      run_phase(1'b1, 13'd40,   1'b1, 32'hFFFF_FFFE, 23, 1'b1);

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Covered %0d requests and %0d results over %0d register settings;",
               reqs_sent, rsp_seen, settings_used + 2);
      $display("%0d out-of-space and %0d range-error results among them.",
               full_seen, range_seen);
      if (mismatch_count == 0 && rsp_owed.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
